FILE: hdl/xenc_pkg.sv
// Shared types and constants of the XML element name counter.
// No dependencies; imported by every module of the block.
package xenc_pkg;

   // Character codes
   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_QMARK = 8'h3F;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_TAB   = 8'h09;

   // Character classes produced by the front end
   localparam logic [1:0] KIND_OTHER = 2'd0;
   localparam logic [1:0] KIND_LT    = 2'd1;
   localparam logic [1:0] KIND_GT    = 2'd2;
   localparam logic [1:0] KIND_SPACE = 2'd3;

   // Register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_LOW  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_HIGH = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET_LEN  = 2'd2;

   localparam int CSR_DATA_BITS  = 64;
   localparam int TARGET_LEN_BITS = 4;
   localparam int FIELD_BITS     = 24;
   localparam int COUNT_BITS     = 24;

   // Parameter defaults
   localparam int MAX_NAME_DEF      = 16;
   localparam int POSITION_BITS_DEF = 24;
   localparam int QUEUE_DEPTH_DEF   = 4;

   // One classified character word
   typedef struct packed {
      logic [1:0] kind;
      logic       slash_q;   // '/' or '?'
      logic [7:0] text;
      logic       last;
   } char_entry_type;

endpackage

FILE: hdl/xenc_front.sv
// Front end: accepts input words and classifies each character.
// Depends on xenc_pkg; feeds xenc_fifo.
module xenc_front
   import xenc_pkg::*;
(
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,
   input  logic           req_tlast,
   input  logic           queue_full,
   output logic           push,
   output char_entry_type entry
);

   logic [1:0] kind;

   always_comb begin
      case (req_tdata)
         CHAR_LT: kind = KIND_LT;
         CHAR_GT: kind = KIND_GT;
         CHAR_SPACE, CHAR_LF, CHAR_CR, CHAR_TAB: kind = KIND_SPACE;
         default: kind = KIND_OTHER;
      endcase
   end

   assign req_tready    = !queue_full;
   assign push          = req_tvalid && !queue_full;
   assign entry.kind    = kind;
   assign entry.slash_q = (req_tdata == CHAR_SLASH) || (req_tdata == CHAR_QMARK);
   assign entry.text    = req_tdata;
   assign entry.last    = req_tlast;

endmodule

FILE: hdl/xenc_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on xenc_pkg for the entry type.
module xenc_fifo
   import xenc_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  char_entry_type push_entry,
   input  logic           pop,
   output char_entry_type pop_entry,
   output logic           empty,
   output logic           full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   char_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("queue read while empty");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue count did not follow a write");

endmodule

FILE: hdl/xenc_back.sv
// Back end: tag parser state, name compare, counters and result register.
// Depends on xenc_pkg; takes classified words from xenc_fifo.
module xenc_back
   import xenc_pkg::*;
#(
   parameter int MAX_NAME      = MAX_NAME_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   input  logic                      queue_empty,
   input  char_entry_type            entry,
   output logic                      pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,
   output logic [1:0]                rsp_tuser,
   output logic                      rsp_tlast
);

   localparam int NL_W = $clog2(MAX_NAME);
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0]    CNT_MAX = {COUNT_BITS{1'b1}};

   // configuration
   logic [CSR_DATA_BITS-1:0]   tgt_low_ff, tgt_high_ff;
   logic [TARGET_LEN_BITS-1:0] tgt_len_ff;

   // stream state
   logic                     inside_tag_ff, inside_tag_in;
   logic                     name_open_ff, name_open_in;
   logic [NL_W-1:0]          name_len_ff, name_len_in;
   logic                     name_mis_ff, name_mis_in;
   logic [1:0]               tag_len_ff, tag_len_in;
   logic                     prev_sq_ff, prev_sq_in;
   logic [POSITION_BITS-1:0] name_start_ff, name_start_in;
   logic [COUNT_BITS-1:0]    match_cnt_ff, match_cnt_in;
   logic [POSITION_BITS-1:0] char_pos_ff, char_pos_in;

   // result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, match_ff, done_ff;
   logic [FIELD_BITS-1:0]    where_ff, total_ff;

   logic                     found, match, ignore, emit;
   logic [POSITION_BITS-1:0] where;
   logic [COUNT_BITS-1:0]    cnt_upd;
   logic [127:0]             target_word;
   logic [3:0]               byte_idx;
   logic [7:0]               tgt_byte;

   assign target_word = {tgt_high_ff, tgt_low_ff};
   assign byte_idx    = 4'(name_len_ff);
   assign tgt_byte    = target_word[{byte_idx, 3'b000} +: 8];

   assign pop  = !queue_empty && (!rsp_valid_ff || rsp_tready);
   assign emit = pop && (found || entry.last);

   always_comb begin
      inside_tag_in = inside_tag_ff;
      name_open_in  = name_open_ff;
      name_len_in   = name_len_ff;
      name_mis_in   = name_mis_ff;
      tag_len_in    = tag_len_ff;
      prev_sq_in    = prev_sq_ff;
      name_start_in = name_start_ff;
      char_pos_in   = char_pos_ff;
      cnt_upd       = match_cnt_ff;
      found         = 1'b0;
      match         = 1'b0;
      ignore        = 1'b0;
      where         = '0;
      if (pop) begin
         if (entry.kind == KIND_LT) begin
            // a '<' opens a tag, and restarts one already open
            inside_tag_in = 1'b1;
            name_open_in  = 1'b1;
            name_len_in   = '0;
            name_mis_in   = 1'b0;
            tag_len_in    = '0;
            name_start_in = (char_pos_ff != POS_MAX) ?
                            char_pos_ff + POSITION_BITS'(1) : POS_MAX;
         end else if (inside_tag_ff) begin
            if (entry.kind == KIND_GT) begin
               ignore = (tag_len_ff == 2'd0) || (tag_len_ff == 2'd1 && prev_sq_ff);
               if (!ignore) begin
                  found = 1'b1;
                  where = name_start_ff;
                  match = !name_mis_ff && (tgt_len_ff != '0) &&
                          (TARGET_LEN_BITS'(name_len_ff) == tgt_len_ff);
                  if (match && match_cnt_ff != CNT_MAX) begin
                     cnt_upd = match_cnt_ff + COUNT_BITS'(1);
                  end
               end
               inside_tag_in = 1'b0;
               name_open_in  = 1'b0;
            end else begin
               if (tag_len_ff != 2'd3) begin
                  tag_len_in = tag_len_ff + 2'd1;
               end
               if (name_open_ff) begin
                  if (entry.kind == KIND_SPACE) begin
                     name_open_in = 1'b0;
                  end else if (name_len_ff < NL_W'(MAX_NAME - 1)) begin
                     if (TARGET_LEN_BITS'(name_len_ff) >= tgt_len_ff ||
                         tgt_byte != entry.text) begin
                        name_mis_in = 1'b1;
                     end
                     name_len_in = name_len_ff + NL_W'(1);
                  end
               end
            end
         end
         prev_sq_in  = entry.slash_q;
         char_pos_in = (char_pos_ff != POS_MAX) ?
                       char_pos_ff + POSITION_BITS'(1) : POS_MAX;
      end
      match_cnt_in = cnt_upd;
      if (pop && entry.last) begin
         // end of document: fresh stream state
         inside_tag_in = 1'b0;
         name_open_in  = 1'b0;
         name_len_in   = '0;
         name_mis_in   = 1'b0;
         tag_len_in    = '0;
         prev_sq_in    = 1'b0;
         name_start_in = '0;
         match_cnt_in  = '0;
         char_pos_in   = '0;
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_low_ff    <= '0;
         tgt_high_ff   <= '0;
         tgt_len_ff    <= TARGET_LEN_BITS'(1);
         inside_tag_ff <= 1'b0;
         name_open_ff  <= 1'b0;
         name_len_ff   <= '0;
         name_mis_ff   <= 1'b0;
         tag_len_ff    <= '0;
         prev_sq_ff    <= 1'b0;
         name_start_ff <= '0;
         match_cnt_ff  <= '0;
         char_pos_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TARGET_LOW:  tgt_low_ff  <= csr_wdata;
               CSR_TARGET_HIGH: tgt_high_ff <= csr_wdata;
               CSR_TARGET_LEN:  tgt_len_ff  <= csr_wdata[TARGET_LEN_BITS-1:0];
               default: ;
            endcase
         end
         inside_tag_ff <= inside_tag_in;
         name_open_ff  <= name_open_in;
         name_len_ff   <= name_len_in;
         name_mis_ff   <= name_mis_in;
         tag_len_ff    <= tag_len_in;
         prev_sq_ff    <= prev_sq_in;
         name_start_ff <= name_start_in;
         match_cnt_ff  <= match_cnt_in;
         char_pos_ff   <= char_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         found_ff <= found;
         match_ff <= match;
         where_ff <= FIELD_BITS'(where);
         total_ff <= cnt_upd;
         done_ff  <= entry.last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {total_ff, where_ff};
   assign rsp_tuser  = {match_ff, found_ff};
   assign rsp_tlast  = done_ff;

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (pop && !entry.last) |=> (match_cnt_ff >= $past(match_cnt_ff)))
      else $error("match count went down inside a document");

   a_name_bound: assert property (@(posedge clock) disable iff (reset)
      name_len_ff <= NL_W'(MAX_NAME - 1))
      else $error("kept name longer than the limit");

   a_name_in_tag: assert property (@(posedge clock) disable iff (reset)
      name_open_ff |-> inside_tag_ff)
      else $error("name open outside a tag");

   a_match_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && match_ff) |-> found_ff)
      else $error("match reported without an element");

endmodule

FILE: hdl/xml_element_name_counter.sv
// Top level of the XML element name counter.
// Depends on xenc_pkg, xenc_front, xenc_fifo and xenc_back.
//
// Usage:
//   req_*  : one document character per word; req_tlast marks the last one.
//   rsp_*  : one word per element that closes on '>' (not "<>", "</>", "<?>"),
//            plus one word for the last character of every document.
//   csr_*  : target name bytes 0..7 (index 0), bytes 8..15 (index 1) and the
//            target length (index 2); write only while the block is idle.
// Throughput is one character per cycle while the receiver accepts: the
// front end classifies a word and drops it in a short queue; the back end
// updates the tag state and the counters for one queued word per cycle. A
// result word passes through the queue slot and then the output register.
// When the receiver stalls, the output register holds its word, the back end
// stops and the queue fills; req_tready falls only once the queue is full.
// Reset (synchronous) empties the queue and output, clears all parse state
// and counters and loads the register reset values (length 1, name zero).
// After each document's last character the parse state and counters clear,
// so the next word starts a new document.
module xml_element_name_counter
   import xenc_pkg::*;
#(
   parameter int MAX_NAME      = MAX_NAME_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // input channel
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] text_char
   input  logic                      req_tlast,   // last_char
   // result channel
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,   // [23:0] element_position,
                                                  // [47:24] match_total
   output logic [1:0]                rsp_tuser,   // [0] element_found,
                                                  // [1] name_matches
   output logic                      rsp_tlast,   // document_done
   // configuration
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   char_entry_type push_entry, pop_entry;
   logic           push, pop, queue_empty, queue_full;

   // classify characters at the input
   xenc_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .entry      (push_entry)
   );

   // decouples input acceptance from result back-pressure
   xenc_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (queue_empty),
      .full       (queue_full)
   );

   // tag parsing, name compare, counters, result register
   xenc_back #(
      .MAX_NAME      (MAX_NAME),
      .POSITION_BITS (POSITION_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .queue_empty (queue_empty),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of xml_element_name_counter: directed tag shapes,
// then random documents under several target names, against a local predictor.
// Depends on xenc_pkg and the block's RTL only; reads no files or arguments.
module tb_top;
   import xenc_pkg::*;

   localparam int NAME_KEEP    = MAX_NAME_DEF - 1;      // name chars kept per tag
   localparam logic [FIELD_BITS-1:0] POS_MAX   = '1;    // POSITION_BITS == 24
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 2'd3;  // no register here
   localparam int DRAIN_CYCLES = 8;     // queue plus output register, with margin
   localparam int QUIET_LIMIT  = 1000;  // cycles with no word moving on either side
   localparam int RANDOM_ITEMS = 810;   // budget; each setting overshoots by part of a doc
   localparam int NUM_SETTINGS = 9;

   // One result word, field by field
   typedef struct packed {
      logic                  found;
      logic                  matched;
      logic [FIELD_BITS-1:0] position;
      logic [COUNT_BITS-1:0] total;
      logic                  done;
   } element_type;

   typedef enum logic {ROW_CHAR, ROW_CSR} row_kind_type;

   // One line of the directed table: a character or a register write
   typedef struct packed {
      row_kind_type              kind;
      logic [CSR_INDEX_BITS-1:0] index;
      logic [CSR_DATA_BITS-1:0]  value;
      logic [7:0]                text;
      logic                      last;
      logic                      typed;   // expected word given in the row
      element_type               want;
   } row_type;

   function automatic row_type char_row(logic [7:0] c, logic last);
      row_type r;
      r = '0;
      r.kind = ROW_CHAR;
      r.text = c;
      r.last = last;
      return r;
   endfunction

   function automatic row_type checked_row(logic [7:0] c, logic last, logic found,
                                           logic hit, logic [23:0] pos,
                                           logic [23:0] total);
      row_type r;
      r = char_row(c, last);
      r.typed = 1'b1;
      r.want = '{found, hit, pos, total, last};
      return r;
   endfunction

   function automatic row_type reg_row(logic [CSR_INDEX_BITS-1:0] index,
                                       logic [CSR_DATA_BITS-1:0] value);
      row_type r;
      r = '0;
      r.kind = ROW_CSR;
      r.index = index;
      r.value = value;
      return r;
   endfunction

   // Directed part. First document runs with the reset target (one 0x00 char).
   localparam row_type DIRECTED [28] = '{
      char_row(CHAR_LT, 1'b0),
      char_row(8'h00, 1'b0),
      checked_row(CHAR_GT, 1'b0, 1'b1, 1'b1, 24'd1, 24'd1),  // reset target hit
      char_row(CHAR_LT, 1'b0),                               // "<>" ignored
      char_row(CHAR_GT, 1'b0),
      char_row(CHAR_LT, 1'b0),                               // "</>" ignored
      char_row(CHAR_SLASH, 1'b0),
      char_row(CHAR_GT, 1'b0),
      char_row(CHAR_LT, 1'b0),                               // "<?>" ignored
      char_row(CHAR_QMARK, 1'b0),
      char_row(CHAR_GT, 1'b0),
      checked_row(8'hFF, 1'b1, 1'b0, 1'b0, 24'd0, 24'd1),    // end, no tag
      reg_row(CSR_TARGET_LOW, 64'h6261),                     // "ab"
      reg_row(CSR_TARGET_LEN, 64'd2),
      reg_row(CSR_UNUSED, '1),                               // must be dropped
      char_row(CHAR_LT, 1'b0),                               // empty name
      char_row(CHAR_SPACE, 1'b0),
      checked_row(CHAR_GT, 1'b0, 1'b1, 1'b0, 24'd1, 24'd0),
      char_row(CHAR_LT, 1'b0),                               // '<' restarts tag
      char_row("a", 1'b0),
      char_row(CHAR_LT, 1'b0),
      char_row("a", 1'b0),
      char_row("b", 1'b0),
      char_row(CHAR_TAB, 1'b0),
      char_row("x", 1'b0),
      char_row(CHAR_GT, 1'b0),
      char_row(CHAR_LT, 1'b0),                               // unclosed at end
      checked_row("a", 1'b1, 1'b0, 1'b0, 24'd0, 24'd1)
   };

   // DUT signals; every input known from time zero
   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata  = '0;   // [7:0] text_char
   logic                      req_tlast  = 1'b0; // last_char
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [47:0]               rsp_tdata;         // [23:0] element_position, [47:24] match_total
   logic [1:0]                rsp_tuser;         // [0] element_found, [1] name_matches
   logic                      rsp_tlast;         // document_done
   logic                      csr_wr_en  = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // Predictor copy of the target registers (reset values)
   logic [CSR_DATA_BITS-1:0]   target_low  = '0;
   logic [CSR_DATA_BITS-1:0]   target_high = '0;
   logic [TARGET_LEN_BITS-1:0] target_len  = 4'd1;

   // Predictor copy of the tag parser
   logic                  in_tag      = 1'b0;
   logic                  name_open   = 1'b0;
   logic [3:0]            name_len    = '0;
   logic                  name_bad    = 1'b0;
   logic [1:0]            tag_len     = '0;   // chars since '<', saturates at 3
   logic [7:0]            prev_char   = '0;
   logic [FIELD_BITS-1:0] name_start  = '0;
   logic [COUNT_BITS-1:0] match_count = '0;
   logic [FIELD_BITS-1:0] char_pos    = '0;

   element_type pending_elements[$];   // words still owed by the block
   logic [7:0]  doc_chars[$];          // document under construction
   string       name_alphabet = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_:-.";

   int fail_count    = 0;
   int chars_sent    = 0;
   int docs_done     = 0;
   int results_seen  = 0;
   int elements_seen = 0;
   int matches_seen  = 0;
   int settings_used = 0;
   int quiet_cycles  = 0;
   bit steady        = 1'b0;   // no idling on either side while set
   bit text_since_write = 1'b0;

   xml_element_name_counter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [7:0] target_char(int unsigned idx);
      if (idx < 8)
         return target_low[idx*8 +: 8];
      return target_high[(idx-8)*8 +: 8];
   endfunction

   // One character through the tag parser. emits is set when the block owes
   // a word for it: a tag that closed, or the last char of the document.
   task automatic parse_char(input logic [7:0] c, input logic last,
                             output bit emits, output element_type res);
      logic [FIELD_BITS-1:0] pos;
      logic                  found;
      logic                  name_hit;
      logic                  skip;
      pos = char_pos;
      found = 1'b0;
      name_hit = 1'b0;
      res = '0;
      if (c == CHAR_LT) begin
         // '<' opens a tag, or restarts the one already open
         in_tag = 1'b1;
         name_open = 1'b1;
         name_len = '0;
         name_bad = 1'b0;
         tag_len = '0;
         name_start = (pos < POS_MAX) ? pos + 24'd1 : POS_MAX;
      end else if (in_tag && c == CHAR_GT) begin
         // "<>", "</>" and "<?>" close without a word
         skip = (tag_len == 2'd0) ||
                (tag_len == 2'd1 && (prev_char == CHAR_SLASH || prev_char == CHAR_QMARK));
         if (!skip) begin
            found = 1'b1;
            res.position = name_start;
            name_hit = !name_bad && target_len != '0 && name_len == target_len;
            if (name_hit && match_count < COUNT_MAX)
               match_count = match_count + 24'd1;
         end
         in_tag = 1'b0;
         name_open = 1'b0;
      end else if (in_tag) begin
         if (tag_len < 2'd3)
            tag_len = tag_len + 2'd1;
         if (name_open) begin
            if (c == CHAR_SPACE || c == CHAR_LF || c == CHAR_CR || c == CHAR_TAB) begin
               name_open = 1'b0;
            end else if (int'(name_len) < NAME_KEEP) begin
               // chars past the kept length are dropped, not compared
               if (name_len >= target_len || target_char(int'(name_len)) != c)
                  name_bad = 1'b1;
               name_len = name_len + 4'd1;
            end
         end
      end
      prev_char = c;
      if (char_pos < POS_MAX)
         char_pos = char_pos + 24'd1;
      emits = found || last;
      res.found = found;
      res.matched = name_hit;
      res.total = match_count;
      res.done = last;
      if (last) begin
         // next char starts a fresh document; registers stay
         in_tag = 1'b0;
         name_open = 1'b0;
         name_len = '0;
         name_bad = 1'b0;
         tag_len = '0;
         prev_char = '0;
         name_start = '0;
         match_count = '0;
         char_pos = '0;
      end
   endtask

   // Present one char and hold it until the block takes it. Random idle
   // cycles go before the word unless the steady stretch is on.
   task automatic push_char(logic [7:0] c, logic last, logic typed, element_type want);
      bit          emits;
      element_type res;
      while (!steady && $urandom_range(99) < 30) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      parse_char(c, last, emits, res);
      if (typed)
         pending_elements.push_back(want);
      else if (emits)
         pending_elements.push_back(res);
      chars_sent++;
      text_since_write = 1'b1;
      if (last)
         docs_done++;
   endtask

   // Stop sending and let the block go idle: all owed words back, then a
   // drain wait for chars that owe nothing but may still sit in the queue.
   task automatic settle();
      if (text_since_write) begin
         req_tvalid <= 1'b0;
         while (pending_elements.size() != 0)
            @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         text_since_write = 1'b0;
      end
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      settle();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_TARGET_LOW:  target_low = value;
         CSR_TARGET_HIGH: target_high = value;
         CSR_TARGET_LEN:  target_len = value[TARGET_LEN_BITS-1:0];
         default: ;       // unknown index: ignored
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [7:0] name_char();
      return name_alphabet[$urandom_range(name_alphabet.len() - 1)];
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(3))
         0:       return CHAR_SPACE;
         1:       return CHAR_LF;
         2:       return CHAR_CR;
         default: return CHAR_TAB;
      endcase
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      for (int i = 0; i < 8; i++)
         w[i*8 +: 8] = name_char();
      return w;
   endfunction

   // One tag, mostly built around the current target name
   task automatic add_tag();
      int unsigned pick;
      logic [7:0]  c;
      doc_chars.push_back(CHAR_LT);
      pick = $urandom_range(9);
      if (pick == 0)
         doc_chars.push_back(CHAR_SLASH);   // closing tag, '/' is part of the name
      else if (pick == 1)
         doc_chars.push_back(CHAR_QMARK);
      case ($urandom_range(9))
         0, 1, 2, 3: begin                    // exact target
            for (int i = 0; i < int'(target_len); i++)
               doc_chars.push_back(target_char(i));
         end
         4: begin                             // at most one char off
            pick = $urandom_range(int'(target_len));
            for (int i = 0; i < int'(target_len); i++) begin
               c = target_char(i);
               if (i == int'(pick))
                  c = c ^ 8'h20;
               doc_chars.push_back(c);
            end
         end
         5: begin                             // one char short
            for (int i = 0; i + 1 < int'(target_len); i++)
               doc_chars.push_back(target_char(i));
         end
         6: begin                             // one char long; truncation at max length
            for (int i = 0; i < int'(target_len); i++)
               doc_chars.push_back(target_char(i));
            doc_chars.push_back(name_char());
         end
         7: repeat ($urandom_range(14, 20)) doc_chars.push_back(name_char());
         8: repeat ($urandom_range(1, 6)) doc_chars.push_back(name_char());
         default: ;                           // empty name
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3, 4: doc_chars.push_back(CHAR_GT);
         5, 6, 7: begin                       // whitespace and attributes
            doc_chars.push_back(space_char());
            repeat ($urandom_range(1, 8)) begin
               case ($urandom_range(5))
                  0:       doc_chars.push_back("=");
                  1:       doc_chars.push_back(8'h22);
                  2:       doc_chars.push_back(space_char());
                  default: doc_chars.push_back(name_char());
               endcase
            end
            doc_chars.push_back(CHAR_GT);
         end
         8: begin                             // "<name/>"
            doc_chars.push_back(CHAR_SLASH);
            doc_chars.push_back(CHAR_GT);
         end
         default: ;                           // never closed
      endcase
   endtask

   // Random document: tags, text and raw bytes; last char flagged
   task automatic send_document();
      int unsigned goal;
      int unsigned sel;
      doc_chars.delete();
      goal = $urandom_range(15, 90);
      while (doc_chars.size() < int'(goal)) begin
         sel = $urandom_range(99);
         if (sel < 70)
            add_tag();
         else if (sel < 85)
            repeat ($urandom_range(1, 6))
               doc_chars.push_back(($urandom_range(4) == 0) ? space_char() : name_char());
         else
            repeat ($urandom_range(1, 3))
               doc_chars.push_back(8'($urandom_range(255)));
      end
      foreach (doc_chars[i])
         push_char(doc_chars[i], i == doc_chars.size() - 1, 1'b0, '0);
   endtask

   // Receiver: stalls at random outside the steady stretch
   always @(posedge clock)
      rsp_tready <= steady || ($urandom_range(99) >= 30);

   function automatic void check_field(string name, logic [23:0] want, logic [23:0] got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Every accepted result word is checked against the oldest owed word
   always @(posedge clock) begin
      element_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0])
            elements_seen++;
         if (rsp_tuser[1])
            matches_seen++;
         if (pending_elements.size() == 0) begin
            $error("result word with nothing owed: tdata %h tuser %b tlast %b",
                   rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            want = pending_elements.pop_front();
            check_field("element_found", 24'(want.found), 24'(rsp_tuser[0]));
            check_field("name_matches", 24'(want.matched), 24'(rsp_tuser[1]));
            check_field("element_position", want.position, rsp_tdata[23:0]);
            check_field("match_total", want.total, rsp_tdata[47:24]);
            check_field("document_done", 24'(want.done), 24'(rsp_tlast));
         end
      end
   end

   // Watchdog: a stuck handshake or a missing word ends the run
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] low_word;
      logic [63:0] high_word;
      logic [3:0]  len;
      int          start;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) begin
         if (DIRECTED[k].kind == ROW_CSR)
            write_reg(DIRECTED[k].index, DIRECTED[k].value);
         else
            push_char(DIRECTED[k].text, DIRECTED[k].last, DIRECTED[k].typed,
                      DIRECTED[k].want);
      end

      // Random documents under a series of targets, extremes first
      for (int s = 0; s < NUM_SETTINGS; s++) begin
         low_word  = random_word();
         high_word = random_word();
         case (s)
            0: len = 4'd15;                   // longest name, both words used
            1: len = 4'd0;                    // nothing can match
            2: begin                          // all-ones name bytes
               low_word  = '1;
               high_word = '1;
               len = 4'd15;
            end
            3: begin                          // name of one 0x00 char
               low_word  = '0;
               high_word = '0;
               len = 4'd1;
            end
            5: len = 4'd9;                    // just past the low word
            default: len = 4'($urandom_range(1, 15));
         endcase
         write_reg(CSR_TARGET_LOW, low_word);
         write_reg(CSR_TARGET_HIGH, high_word);
         write_reg(CSR_TARGET_LEN, {60'd0, len});
         settings_used++;
         steady = (s == 4 || s == 5);
         start = chars_sent;
         while (chars_sent - start < RANDOM_ITEMS / NUM_SETTINGS)
            send_document();
      end
      steady = 1'b0;
      settle();

      $display("Sent %0d chars in %0d documents: directed table plus %0d target settings.",
               chars_sent, docs_done, settings_used);
      $display("Checked %0d result words: %0d closed elements, %0d name matches.",
               results_seen, elements_seen, matches_seen);
      if (fail_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
